// ===== sv/pgs_sup_pkg.sv =====
package pgs_sup_pkg;

  // Field widths fixed by the stream format.
  localparam int TS_W   = 33;
  localparam int BASE_W = 32;
  localparam int NUM_W  = 16;
  localparam int DEN_W  = 30;
  localparam int SCL_W  = 32;

  // Scaler datapath widths: |ts - base| fits 33 bits, num * 1000 fits 26 bits.
  localparam int MAG_W     = 33;
  localparam int K_W       = 26;
  localparam int PROD_W    = MAG_W + K_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TS_BASE = 2'd0;
  localparam logic [1:0] CFG_TB_NUM  = 2'd1;
  localparam logic [1:0] CFG_TB_DEN  = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET = '0;
  localparam logic [NUM_W-1:0]  NUM_RESET  = 16'd90;
  localparam logic [DEN_W-1:0]  DEN_RESET  = 30'd1000;

  // Header run: "PG", four PTS bytes, four DTS bytes, then the type byte.
  localparam logic [7:0] MARK_P       = 8'h50;
  localparam logic [7:0] MARK_G       = 8'h47;
  localparam logic [3:0] HDR_LAST_IDX = 4'd10;

  typedef struct packed {
    logic [7:0]      in_byte;
    logic [TS_W-1:0] pkt_pts;
    logic [TS_W-1:0] pkt_dts;
    logic            last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
  } out_item_t;

  // One queued transaction as classified by the front end.
  typedef struct packed {
    logic [7:0]       data;
    logic             hdr;
    logic             last;
    logic [SCL_W-1:0] pts;
    logic [SCL_W-1:0] dts;
  } queue_entry_t;

  typedef struct packed {
    logic              start;
    logic [TS_W-1:0]   ts;
    logic [BASE_W-1:0] base;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } scale_req_t;

  typedef struct packed {
    logic             done;
    logic [SCL_W-1:0] result;
  } scale_rsp_t;

  typedef enum logic [1:0] {
    SEG_TYPE,
    SEG_LEN_HI,
    SEG_LEN_LO,
    SEG_PAYLOAD
  } seg_phase_t;

  typedef enum logic [1:0] {
    FR_WAIT,
    FR_PTS,
    FR_DTS,
    FR_RUN
  } front_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_FIX
  } scale_state_t;

endpackage

// ===== sv/pgs_sup_scaler.sv =====
module pgs_sup_scaler (
  input  logic                    clk,
  input  logic                    rst,
  input  pgs_sup_pkg::scale_req_t req,
  output pgs_sup_pkg::scale_rsp_t rsp
);
  import pgs_sup_pkg::*;

  scale_state_t state, state_next;

  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic [K_W-1:0]    k;
  logic [DEN_W-1:0]  den;
  logic [PROD_W-1:0] dvd;
  logic [DEN_W-1:0]  rem;
  logic [SCL_W-1:0]  quo;
  logic [STEP_W-1:0] step;

  logic [MAG_W:0]    diff;
  logic [DEN_W:0]    rem_sh;
  logic              take;
  logic              load;

  // Signed difference ts - base, one bit wider than the wider operand.
  assign diff   = {1'b0, req.ts} - {2'b0, req.base};
  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign take   = rem_sh >= {1'b0, den};
  assign load   = req.start && (state == SC_IDLE || state == SC_FIX);

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: if (load) state_next = SC_MUL;
      SC_MUL:  state_next = SC_DIV;
      SC_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = SC_FIX;
      SC_FIX:  state_next = load ? SC_MUL : SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state == SC_FIX);
    rsp.result = neg ? (SCL_W'(0) - quo) : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= diff[MAG_W];
      mag <= diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      k   <= K_W'(req.num) * K_W'(MS_PER_S);
      den <= (req.den == '0) ? DEN_W'(1) : req.den;
    end
    if (state == SC_MUL) begin
      dvd  <= mag * k;
      rem  <= '0;
      quo  <= '0;
      step <= '0;
    end
    if (state == SC_DIV) begin
      // Restoring division, one quotient bit per cycle.
      rem  <= take ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quo  <= {quo[SCL_W-2:0], take};
      dvd  <= {dvd[PROD_W-2:0], 1'b0};
      step <= step + STEP_W'(1);
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == SC_IDLE || state == SC_FIX))
    else $error("scaler started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done && !req.start |=> !rsp.done)
    else $error("scaler done held without a new request");

endmodule

// ===== sv/pgs_sup_fifo.sv =====
module pgs_sup_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  pgs_sup_pkg::queue_entry_t push_entry,
  input  logic                      pop,
  output pgs_sup_pkg::queue_entry_t head,
  output logic                      empty,
  output logic                      full
);
  import pgs_sup_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  queue_entry_t  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== sv/pgs_sup_front.sv =====
module pgs_sup_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pgs_sup_pkg::in_item_t     in_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output pgs_sup_pkg::scale_req_t   req,
  input  pgs_sup_pkg::scale_rsp_t   rsp,
  output logic                      push,
  output pgs_sup_pkg::queue_entry_t push_entry,
  input  logic                      full
);
  import pgs_sup_pkg::*;

  front_state_t state, state_next;

  logic [BASE_W-1:0] ts_base;
  logic [NUM_W-1:0]  tb_num;
  logic [DEN_W-1:0]  tb_den;
  logic [SCL_W-1:0]  scaled_pts;
  logic [SCL_W-1:0]  scaled_dts;

  seg_phase_t        phase, phase_next;
  logic [15:0]       payload_left, payload_left_next;
  logic [7:0]        len_high, len_high_next;
  logic [15:0]       pl_dec;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_base <= BASE_RESET;
      tb_num  <= NUM_RESET;
      tb_den  <= DEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TS_BASE: ts_base <= cfg_data;
        CFG_TB_NUM:  tb_num  <= cfg_data[NUM_W-1:0];
        CFG_TB_DEN:  tb_den  <= cfg_data[DEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // Next state: both timestamps of a new packet are scaled before its first
  // byte is taken.
  always_comb begin
    state_next = state;
    case (state)
      FR_WAIT: if (in_valid) state_next = FR_PTS;
      FR_PTS:  if (rsp.done) state_next = FR_DTS;
      FR_DTS:  if (rsp.done) state_next = FR_RUN;
      FR_RUN:  if (accept && in_item.last_byte) state_next = FR_WAIT;
      default: state_next = FR_WAIT;
    endcase
  end

  always_comb begin
    in_ready  = (state == FR_RUN) && !full;
    req.start = (state == FR_WAIT && in_valid) || (state == FR_PTS && rsp.done);
    req.ts    = (state == FR_WAIT) ? in_item.pkt_pts : in_item.pkt_dts;
    req.base  = ts_base;
    req.num   = tb_num;
    req.den   = tb_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_PTS && rsp.done) begin
      scaled_pts <= rsp.result;
    end
    if (state == FR_DTS && rsp.done) begin
      scaled_dts <= rsp.result;
    end
  end

  // Segment tracking: type byte, two length bytes, then the payload.
  assign pl_dec = (payload_left != '0) ? payload_left - 16'd1 : payload_left;

  always_comb begin
    phase_next        = phase;
    payload_left_next = payload_left;
    len_high_next     = len_high;
    case (phase)
      SEG_TYPE: phase_next = SEG_LEN_HI;
      SEG_LEN_HI: begin
        len_high_next = in_item.in_byte;
        phase_next    = SEG_LEN_LO;
      end
      SEG_LEN_LO: begin
        payload_left_next = {len_high, in_item.in_byte};
        phase_next = ({len_high, in_item.in_byte} == 16'd0) ? SEG_TYPE : SEG_PAYLOAD;
      end
      SEG_PAYLOAD: begin
        payload_left_next = pl_dec;
        if (pl_dec == '0) phase_next = SEG_TYPE;
      end
      default: phase_next = SEG_TYPE;
    endcase
    if (in_item.last_byte) begin
      phase_next        = SEG_TYPE;
      payload_left_next = '0;
      len_high_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= SEG_TYPE;
      payload_left <= '0;
      len_high     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      payload_left <= payload_left_next;
      len_high     <= len_high_next;
    end
  end

  always_comb begin
    push            = accept;
    push_entry.data = in_item.in_byte;
    push_entry.hdr  = (phase == SEG_TYPE);
    push_entry.last = in_item.last_byte;
    push_entry.pts  = scaled_pts;
    push_entry.dts  = scaled_dts;
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == SEG_PAYLOAD |-> payload_left != '0)
    else $error("payload phase with nothing left to pass");

endmodule

// ===== sv/pgs_sup_back.sv =====
module pgs_sup_back (
  input  logic                      clk,
  input  logic                      rst,
  input  pgs_sup_pkg::queue_entry_t head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pgs_sup_pkg::out_item_t    out_item
);
  import pgs_sup_pkg::*;

  logic [3:0] idx;
  logic       final_byte;
  logic       load;
  logic [7:0] sel_byte;

  assign final_byte = !head.hdr || (idx == HDR_LAST_IDX);
  assign load       = !empty && (!out_valid || out_ready);
  assign pop        = load && final_byte;

  always_comb begin
    sel_byte = head.data;
    if (head.hdr) begin
      case (idx)
        4'd0:    sel_byte = MARK_P;
        4'd1:    sel_byte = MARK_G;
        4'd2:    sel_byte = head.pts[31:24];
        4'd3:    sel_byte = head.pts[23:16];
        4'd4:    sel_byte = head.pts[15:8];
        4'd5:    sel_byte = head.pts[7:0];
        4'd6:    sel_byte = head.dts[31:24];
        4'd7:    sel_byte = head.dts[23:16];
        4'd8:    sel_byte = head.dts[15:8];
        4'd9:    sel_byte = head.dts[7:0];
        default: sel_byte = head.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 4'd0 : idx + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_byte   <= sel_byte;
      out_item.run_last   <= final_byte;
      out_item.packet_end <= final_byte && head.last;
    end
  end

  a_run_has_entry: assert property (@(posedge clk) disable iff (rst)
    idx != 4'd0 |-> !empty && head.hdr)
    else $error("header run in progress without its queue entry");

endmodule

// ===== sv/pgs_segment_sup_reframer_top.sv =====
// Channel | Handshake            | Payload                             | Direction
// in      | in_valid / in_ready  | in_item (byte, pts, dts, last flag) | into block
// out     | out_valid / out_ready| out_item (byte, run_last, pkt_end)  | out of block
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data                 | into block
//
// A packet's first byte waits while the shared scaler works out both stamps, each
// through setup, multiply, 59 division steps and result, the second setup
// overlapping the first result. Later bytes are taken one per cycle while the queue
// has room; the back end sends one byte per cycle while the consumer is ready, and 11
// bytes for a type byte. Reset is synchronous and restores the default time base.
// A stalled output fills the queue, then input waits; config writes are always taken.
module pgs_segment_sup_reframer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pgs_sup_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pgs_sup_pkg::out_item_t out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import pgs_sup_pkg::*;

  // Scaler request and response between the front end and the shared unit.
  scale_req_t   req;
  scale_rsp_t   rsp;

  // Queue between the classifier and the byte emitter. Each entry carries the
  // scaled timestamps of its own packet, so the front end may start scaling
  // the next packet while the back end still emits headers of this one.
  logic         push;
  queue_entry_t push_entry;
  logic         pop;
  queue_entry_t head;
  logic         empty;
  logic         full;

  pgs_sup_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req),
    .rsp        (rsp),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  pgs_sup_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  pgs_sup_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // The back end keeps an output register, so a finished byte can wait for
  // the consumer while the queue keeps accepting transactions.
  pgs_sup_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== tb/tb_pgs_segment_sup_reframer_top.sv =====
`timescale 1ns / 1ps

module tb_pgs_segment_sup_reframer_top;
  import pgs_sup_pkg::*;

  // A hand-computed header: when typed is set, the PTS and DTS words of a
  // type byte's header run are taken from here instead of from the scaler
  // model, so that a few rows are checked against values worked out by hand.
  typedef struct packed {
    logic        typed;
    logic [31:0] pts;
    logic [31:0] dts;
  } hand_stamp_t;

  typedef struct packed {
    in_item_t    item;
    hand_stamp_t stamp;
  } byte_row_t;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every input of the block starts at a known value.
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_TS_BASE;
  logic [31:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_ready;

  pgs_segment_sup_reframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the time base registers, updated whenever a configuration
  // transaction is taken by the block.
  logic [31:0] ts_base = BASE_RESET;
  logic [15:0] ts_mult = NUM_RESET;
  logic [29:0] ts_div  = DEN_RESET;

  // Segment tracking state of the reframer as we expect it to be.
  seg_phase_t  phase_r        = SEG_TYPE;
  logic [15:0] bytes_left     = '0;
  logic [7:0]  len_msb        = '0;
  logic [31:0] pkt_pts_scaled = '0;
  logic [31:0] pkt_dts_scaled = '0;
  logic        in_packet      = 1'b0;

  // Reframed bytes that the block still owes us, oldest first, and the hand
  // values that travel alongside each input byte in the order it is sent.
  out_item_t   frame_q [$];
  hand_stamp_t hand_stamp_q [$];
  byte_row_t   directed_rows [$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int fail_count    = 0;
  int n_in          = 0;
  int n_out         = 0;
  int n_pkts        = 0;
  int n_settings    = 0;

  // (ts - base) * mult * 1000 / div in signed 64-bit arithmetic. SystemVerilog
  // division of signed operands truncates toward zero, as the format wants,
  // and a zero divisor counts as one.
  function automatic logic [31:0] scale_stamp(input logic [32:0] ts);
    longint diff;
    longint prod;
    longint div;
    longint quo;
    diff = $signed({31'd0, ts}) - $signed({32'd0, ts_base});
    prod = diff * $signed({48'd0, ts_mult}) * 64'sd1000;
    div  = (ts_div == '0) ? 64'sd1 : $signed({34'd0, ts_div});
    quo  = prod / div;
    return quo[31:0];
  endfunction

  // Works out the reframed bytes caused by one accepted input byte and
  // queues them. A type byte is preceded by "PG" and both scaled stamps; every
  // byte is then passed through, flagged as the last of its run.
  function automatic void reframe_step(input in_item_t it, input hand_stamp_t hs);
    logic [79:0] hdr;
    logic [31:0] pts;
    logic [31:0] dts;
    out_item_t   r;
    // The stamps are latched on the first byte of each packet only.
    if (!in_packet) begin
      pkt_pts_scaled = scale_stamp(it.pkt_pts);
      pkt_dts_scaled = scale_stamp(it.pkt_dts);
      in_packet      = 1'b1;
    end
    pts = hs.typed ? hs.pts : pkt_pts_scaled;
    dts = hs.typed ? hs.dts : pkt_dts_scaled;
    if (phase_r == SEG_TYPE) begin
      hdr = {MARK_P, MARK_G, pts, dts};
      for (int k = 0; k < 10; k++) begin
        r.out_byte   = hdr[79 - 8 * k -: 8];
        r.run_last   = 1'b0;
        r.packet_end = 1'b0;
        frame_q = {frame_q, r};
      end
    end
    case (phase_r)
      SEG_TYPE: begin
        phase_r = SEG_LEN_HI;
      end
      SEG_LEN_HI: begin
        len_msb = it.in_byte;
        phase_r = SEG_LEN_LO;
      end
      SEG_LEN_LO: begin
        // Both length bytes count as plain unsigned values.
        bytes_left = {len_msb, it.in_byte};
        phase_r    = (bytes_left == '0) ? SEG_TYPE : SEG_PAYLOAD;
      end
      default: begin
        if (bytes_left != '0) bytes_left = bytes_left - 16'd1;
        if (bytes_left == '0) phase_r = SEG_TYPE;
      end
    endcase
    r.out_byte   = it.in_byte;
    r.run_last   = 1'b1;
    r.packet_end = it.last_byte;
    frame_q = {frame_q, r};
    // The end of a packet drops any half-read segment; the stamps are kept.
    if (it.last_byte) begin
      phase_r    = SEG_TYPE;
      bytes_left = '0;
      len_msb    = '0;
      in_packet  = 1'b0;
    end
  endfunction

  // Everything that happens at a clock edge is handled in one place, so that
  // a byte accepted and passed out in the same cycle is always queued before
  // it is compared. All signals are sampled as they stood before the edge.
  always @(posedge clk) begin : scoreboard
    hand_stamp_t hs;
    out_item_t   want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TS_BASE: ts_base = cfg_data;
          CFG_TB_NUM:  ts_mult = cfg_data[15:0];
          CFG_TB_DEN:  ts_div  = cfg_data[29:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (hand_stamp_q.size() != 0) hs = hand_stamp_q.pop_front();
        else hs = '0;
        reframe_step(in_item, hs);
        n_in++;
        if (in_item.last_byte) n_pkts++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected output byte %02h, nothing was pending",
                   $time, out_item.out_byte);
          fail_count++;
        end else begin
          want = frame_q.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.out_byte, out_item.out_byte);
            fail_count++;
          end
          if (out_item.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b actual %b",
                     $time, want.run_last, out_item.run_last);
            fail_count++;
          end
          if (out_item.packet_end !== want.packet_end) begin
            $display("%0t: packet_end expected %b actual %b",
                     $time, want.packet_end, out_item.packet_end);
            fail_count++;
          end
        end
      end
    end
  end

  // The receiver stalls at random, as often as the current phase asks.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Presents one packet byte and holds it until the block takes it. The sender
  // may first sit idle for a random number of cycles. Valid is only ever
  // assigned once per edge, so back-to-back transactions keep it high.
  task automatic send_byte(input in_item_t it, input hand_stamp_t hs);
    hand_stamp_q = {hand_stamp_q, hs};
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits until every reframed byte has come out, then lets the block finish
  // up before the registers are touched again.
  task automatic wait_drained();
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic [32:0] pts,
                         input logic [32:0] dts, input logic last,
                         input logic typed, input logic [31:0] e_pts,
                         input logic [31:0] e_dts);
    byte_row_t row;
    row.item.in_byte   = b;
    row.item.pkt_pts   = pts;
    row.item.pkt_dts   = dts;
    row.item.last_byte = last;
    row.stamp.typed    = typed;
    row.stamp.pts      = e_pts;
    row.stamp.dts      = e_dts;
    directed_rows = {directed_rows, row};
  endtask

  // Random packets until about quota bytes have been sent. Most segments are
  // well formed with a short payload; the rest cut the packet off on the type
  // byte, on the high length byte, or part way into a long payload.
  task automatic random_packets(input int quota);
    int          sent;
    int          nseg;
    int          kind;
    int          len;
    logic        cut;
    logic [63:0] rnd;
    logic [32:0] pts;
    logic [32:0] dts;
    in_item_t    it;
    in_item_t    pkt [$];
    sent = 0;
    while (sent < quota) begin
      rnd = {$urandom, $urandom};
      pts = rnd[32:0];
      rnd = {$urandom, $urandom};
      dts = rnd[32:0];
      // Now and then land right around the base, on either side of it.
      if ($urandom_range(0, 3) == 0) pts = {1'b0, ts_base} + $urandom_range(0, 6) - 3;
      if ($urandom_range(0, 3) == 0) dts = {1'b0, ts_base} + $urandom_range(0, 6) - 3;
      it.pkt_pts   = pts;
      it.pkt_dts   = dts;
      it.last_byte = 1'b0;
      pkt.delete();
      cut  = 1'b0;
      nseg = $urandom_range(1, 3);
      for (int s = 0; s < nseg && !cut; s++) begin
        kind = $urandom_range(0, 9);
        it.in_byte = 8'($urandom_range(0, 255));
        pkt = {pkt, it};
        if (kind <= 6) begin
          len = $urandom_range(0, 6);
          it.in_byte = 8'h00;
          pkt = {pkt, it};
          it.in_byte = 8'(len);
          pkt = {pkt, it};
          for (int k = 0; k < len; k++) begin
            it.in_byte = 8'($urandom_range(0, 255));
            pkt = {pkt, it};
          end
        end else if (kind == 7) begin
          cut = 1'b1;
        end else begin
          it.in_byte = 8'($urandom_range(0, 255));
          pkt = {pkt, it};
          if (kind == 9) begin
            it.in_byte = 8'($urandom_range(0, 255));
            pkt = {pkt, it};
            len = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
              it.in_byte = 8'($urandom_range(0, 255));
              pkt = {pkt, it};
            end
          end
          cut = 1'b1;
        end
      end
      it = pkt[pkt.size() - 1];
      it.last_byte = 1'b1;
      pkt[pkt.size() - 1] = it;
      for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], '0);
      sent += pkt.size();
    end
  endtask

  // One phase: a new time base, written while the block is idle, then random
  // packets under the given sender idling and receiver stalling.
  task automatic run_phase(input logic [31:0] base, input logic [31:0] mult,
                           input logic [31:0] div, input int idle_pct,
                           input int stall_pct, input int quota);
    write_reg(CFG_TS_BASE, base);
    write_reg(CFG_TB_NUM, mult);
    write_reg(CFG_TB_DEN, div);
    cfg_valid <= 1'b0;
    n_settings++;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    random_packets(quota);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : stimulus
    byte_row_t row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    n_settings = 1;

    // Directed packets under the reset time base (base 0, 90 / 1000), so a
    // stamp t scales to 90 * t. Typed rows carry that value worked out by hand.
    //
    // First packet: a two byte payload with both extreme byte values, then a
    // zero-length segment whose type byte carries other stamps to show the latch
    // holds, and a segment with a high length byte of 0x80 that the packet cuts
    // off part way through.
    add_row(8'h16, 33'd1000, 33'd0, 1'b0, 1'b1, 32'h0001_5F90, 32'h0000_0000);
    add_row(8'h00, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'h02, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'hFF, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'h00, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'h80, 33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF, 1'b0, 1'b1,
            32'h0001_5F90, 32'h0000_0000);
    add_row(8'h00, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'h00, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'h17, 33'd1000, 33'd0, 1'b0, 1'b1, 32'h0001_5F90, 32'h0000_0000);
    add_row(8'h80, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'hFF, 33'd1000, 33'd0, 1'b0, 1'b0, '0, '0);
    add_row(8'hAA, 33'd1000, 33'd0, 1'b1, 1'b0, '0, '0);
    // A packet that is nothing but a type byte with the largest PTS; the low
    // 32 bits of 90 * (2^33 - 1) are 0xFFFFFFA6.
    add_row(8'h14, 33'h1_FFFF_FFFF, 33'd0, 1'b1, 1'b1, 32'hFFFF_FFA6, 32'h0000_0000);
    // A type byte of 0xFF with the largest length, cut off after one byte.
    add_row(8'hFF, 33'd0, 33'd1, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_005A);
    add_row(8'hFF, 33'd0, 33'd1, 1'b0, 1'b0, '0, '0);
    add_row(8'hFF, 33'd0, 33'd1, 1'b0, 1'b0, '0, '0);
    add_row(8'h55, 33'd0, 33'd1, 1'b1, 1'b0, '0, '0);

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      send_byte(row.item, row.stamp);
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases. The first uses the extremes: the largest base, so about half
    // the stamps fall below it and scale to negative values, the largest
    // multiplier and a divisor of one. Then the smallest multiplier with a divisor
    // of one billion, a zero divisor, a zero multiplier with every divisor bit set
    // (only the low 30 bits count), and a fully random setting. The idling pattern
    // changes from phase to phase.
    run_phase(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd1, 0, 0, 40);
    run_phase($urandom, 32'd1, 32'd1_000_000_000, 80, 0, 40);
    run_phase($urandom, $urandom_range(1, 65535), 32'd0, 0, 80, 40);
    run_phase(32'h0000_0000, 32'h5A5A_0000, 32'hFFFF_FFFF, 10, 10, 40);
    run_phase($urandom, $urandom_range(1, 65535), $urandom_range(1, 1_000_000_000),
              0, 0, 40);

    // Final drain, bounded, then a quiet spell to catch any stray bytes.
    @(posedge clk);
    for (int w = 0; w < 20000 && frame_q.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (frame_q.size() != 0) begin
      $display("%0t: %0d reframed bytes never came out, next expected %02h",
               $time, frame_q.size(), frame_q[0].out_byte);
      fail_count++;
    end

    $display("Sent %0d packet bytes in %0d packets across %0d time base settings.",
             n_in, n_pkts, n_settings);
    $display("Compared %0d reframed bytes and found %0d mismatches.", n_out, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including a full scaler pass
  // for every packet and the heaviest receiver stalling.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
